### src/dtt_pkg.sv
package dtt_pkg;

  // field widths
  localparam int DiffWidth   = 48;
  localparam int DivWidth    = 32;
  localparam int WordWidth   = 64;
  localparam int WordCount   = 4;
  localparam int IndexWidth  = 2;
  localparam int TargetWidth = WordWidth * WordCount;

  // numerator (2^224-1) << 16: ones from bit 239 down to bit 16
  localparam int NumerBits     = 240;
  localparam int NumerLowZeros = 16;

  // quotient bits resolved per pipeline stage
  localparam int BitsPerStage = 4;
  localparam int StageCount   = NumerBits / BitsPerStage;

  localparam logic [IndexWidth-1:0] LastIndex = IndexWidth'(WordCount - 1);

  // numerator bits handled by stage g, most significant at the top
  function automatic logic [BitsPerStage-1:0] numer_slice(int g);
    logic [BitsPerStage-1:0] slice;
    int p;
    slice = '0;
    for (int j = 0; j < BitsPerStage; j++) begin
      p = NumerBits - 1 - g * BitsPerStage - (BitsPerStage - 1 - j);
      slice[j] = (p >= NumerLowZeros);
    end
    return slice;
  endfunction

  // offset of stage g's partial quotient in the packed triangle
  function automatic int tri_offset(int g);
    int off;
    off = 0;
    for (int s = 0; s < g; s++) begin
      off = off + (s + 1) * BitsPerStage;
    end
    return off;
  endfunction

  localparam int TriBits = tri_offset(StageCount);

endpackage

### src/dtt_div_step.sv
module dtt_div_step (
  input  logic [dtt_pkg::DivWidth-1:0]     rem_i,
  input  logic [dtt_pkg::DivWidth-1:0]     divisor_i,
  input  logic [dtt_pkg::BitsPerStage-1:0] numer_i,
  output logic [dtt_pkg::DivWidth-1:0]     rem_o,
  output logic [dtt_pkg::BitsPerStage-1:0] quot_o
);
  import dtt_pkg::*;

  // restoring division, one quotient bit per compare and subtract
  always_comb begin
    logic [DivWidth:0]   cur;
    logic [DivWidth-1:0] rem;
    rem    = rem_i;
    cur    = '0;
    quot_o = '0;
    for (int j = BitsPerStage - 1; j >= 0; j--) begin
      cur = {rem, numer_i[j]};
      if (cur >= {1'b0, divisor_i}) begin
        quot_o[j] = 1'b1;
        cur       = cur - {1'b0, divisor_i};
      end
      rem = cur[DivWidth-1:0];
    end
    rem_o = rem;
  end

endmodule

### src/difficulty_to_target_divider.sv
// channel | dir | handshake               | payload
// input   | in  | in_valid_i / in_stall_o | difficulty_q16_i
// output  | out | out_valid_o/ out_stall_i| target_word_o, word_index_o, last_word_o
//
// one input beat gives four output beats, least significant word first
// a new difficulty is taken every cycle while the 60-stage divider moves;
// the four-beat word serializer sets the sustained rate: it loads an item only
// when empty or as the last word of the one before is taken; the first word goes
// through the input register, 60 divide stages of 4 quotient bits, serializer load
// rst_ni clears all valid bits and the word counter at once
// a full serializer freezes the whole divide pipeline; nothing is dropped
module difficulty_to_target_divider (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [dtt_pkg::DiffWidth-1:0]    difficulty_q16_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [dtt_pkg::WordWidth-1:0]    target_word_o,
  output logic [dtt_pkg::IndexWidth-1:0]   word_index_o,
  output logic                             last_word_o
);
  import dtt_pkg::*;

  logic                  advance;
  logic                  load;
  logic                  last_valid;

  logic                  in_valid_q;
  logic                  in_zero_q;
  logic [DivWidth-1:0]   in_div_q;

  logic [StageCount-1:0] valid_q;
  logic [StageCount-1:0] zero_q;
  logic [DivWidth-1:0]   div_q [StageCount];
  logic [DivWidth-1:0]   rem_q [StageCount];
  wire  [TriBits-1:0]    quot_tri;

  logic                  out_valid_q;
  logic [IndexWidth-1:0] idx_q;
  logic [TargetWidth-1:0] shift_q;

  // pipeline moves unless the last stage holds an item the serializer cannot take
  assign last_valid = valid_q[StageCount-1];
  assign load       = last_valid && (!out_valid_q || (!out_stall_i && idx_q == LastIndex));
  assign advance    = !last_valid || load;
  assign in_stall_o = !advance;

  // input stage: saturate divisor, flag zero difficulty
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (advance) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      in_zero_q <= (difficulty_q16_i == '0);
      in_div_q  <= (|difficulty_q16_i[DiffWidth-1:DivWidth]) ? '1
                                                            : difficulty_q16_i[DivWidth-1:0];
    end
  end

  // divide stages
  for (genvar g = 0; g < StageCount; g++) begin : gen_stage
    logic                              prev_valid;
    logic                              prev_zero;
    logic [DivWidth-1:0]               prev_div;
    logic [DivWidth-1:0]               prev_rem;
    logic [DivWidth-1:0]               step_rem;
    logic [BitsPerStage-1:0]           step_quot;
    logic [(g+1)*BitsPerStage-1:0]     quot_q;

    if (g == 0) begin : gen_first
      assign prev_valid = in_valid_q;
      assign prev_zero  = in_zero_q;
      assign prev_div   = in_div_q;
      assign prev_rem   = '0;
      always_ff @(posedge clk_i) begin
        if (advance) begin
          quot_q <= step_quot;
        end
      end
    end else begin : gen_rest
      assign prev_valid = valid_q[g-1];
      assign prev_zero  = zero_q[g-1];
      assign prev_div   = div_q[g-1];
      assign prev_rem   = rem_q[g-1];
      always_ff @(posedge clk_i) begin
        if (advance) begin
          quot_q <= {quot_tri[tri_offset(g-1) +: g*BitsPerStage], step_quot};
        end
      end
    end

    assign quot_tri[tri_offset(g) +: (g+1)*BitsPerStage] = quot_q;

    dtt_div_step u_step (
      .rem_i     (prev_rem),
      .divisor_i (prev_div),
      .numer_i   (numer_slice(g)),
      .rem_o     (step_rem),
      .quot_o    (step_quot)
    );

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[g] <= 1'b0;
      end else if (advance) begin
        valid_q[g] <= prev_valid;
      end
    end

    always_ff @(posedge clk_i) begin
      if (advance) begin
        zero_q[g] <= prev_zero;
        div_q[g]  <= prev_div;
        rem_q[g]  <= step_rem;
      end
    end
  end

  // word serializer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else if (load) begin
      out_valid_q <= 1'b1;
      idx_q       <= '0;
    end else if (out_valid_q && !out_stall_i) begin
      if (idx_q == LastIndex) begin
        out_valid_q <= 1'b0;
      end
      idx_q <= idx_q + IndexWidth'(1);
    end
  end

  // word serializer data, zero difficulty gives an all-zero target
  always_ff @(posedge clk_i) begin
    if (load) begin
      shift_q <= zero_q[StageCount-1] ? '0
               : TargetWidth'(quot_tri[tri_offset(StageCount-1) +: NumerBits]);
    end else if (out_valid_q && !out_stall_i) begin
      shift_q <= shift_q >> WordWidth;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign target_word_o = shift_q[WordWidth-1:0];
  assign word_index_o  = idx_q;
  assign last_word_o   = (idx_q == LastIndex);

  // a held input beat means the last stage is blocked
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> last_valid && out_valid_o)
    else $error("input stalled without a blocked last stage");

  // beats of one item come in order without gaps
  a_word_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && word_index_o != LastIndex |=>
      out_valid_o && word_index_o == $past(word_index_o) + IndexWidth'(1))
    else $error("word sequence broken");

  // every item starts at the least significant word
  a_first_word : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> word_index_o == '0)
    else $error("item did not start at word zero");

  // the serializer loads only on a completed item or when empty
  a_load_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> !out_valid_o || (!out_stall_i && last_word_o))
    else $error("serializer overwritten");

endmodule
